>>> hw/rtl/percentile_contrast_stretch_top_macros.svh
// Assertion macros for the percentile contrast stretch block.
`ifndef PERCENTILE_CONTRAST_STRETCH_TOP_MACROS_SVH
`define PERCENTILE_CONTRAST_STRETCH_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define PCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PCS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PCS_ASSERT(lbl, prop, msg)
`define PCS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> hw/rtl/pcs_pkg.sv
// Shared constants and controller-to-datapath command type for the contrast stretch.
`default_nettype none
package pcs_pkg;
  localparam int LEVEL_W = 8;
  localparam int LEVELS = 256;
  localparam int COUNT_W = 21;
  localparam int FRAC_W = 17;
  localparam int LIMIT_W = FRAC_W + COUNT_W;
  localparam int IDX_W = LEVEL_W + 1;
  localparam int DIV_STEPS = LEVEL_W;
  localparam logic [COUNT_W-1:0] MAX_FRAME_PIXELS = COUNT_W'(1048576);
  localparam logic [FRAC_W-1:0] BOTTOM_RESET = FRAC_W'(13107);
  localparam logic [FRAC_W-1:0] UPPER_RESET = FRAC_W'(52429);
  localparam logic [LEVEL_W-1:0] OUT_MAX = LEVEL_W'(255);
  localparam logic REG_BOTTOM = 1'b0;
  localparam logic REG_UPPER = 1'b1;
  localparam logic CMD_COUNT = 1'b0;
  localparam logic CMD_MAP = 1'b1;
  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_MAP = 1'b1;

  typedef struct packed {
    logic hist_rd;
    logic hist_inc;
    logic tab_rd;
    logic out_map;
    logic out_rep;
    logic clr;
    logic acc;
    logic walk_start;
    logic div_start;
    logic div_step;
    logic fill;
    logic [IDX_W-1:0] idx;
  } pcs_cmd_t;

  typedef struct packed {
    logic out_free;
  } pcs_status_t;
endpackage
`default_nettype wire

>>> hw/rtl/pcs_dp.sv
// Datapath: histogram and table memories, limits, walk, divider, fill and output register.
`default_nettype none
module pcs_dp
  import pcs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire pcs_cmd_t cmd,
  output pcs_status_t status,
  input  wire logic cfg_we,
  input  wire logic cfg_index,
  input  wire logic [FRAC_W-1:0] cfg_data,
  input  wire logic [LEVEL_W-1:0] pixel,
  output logic out_valid,
  input  wire logic out_stall,
  output logic kind,
  output logic [LEVEL_W-1:0] mapped_pixel,
  output logic [LEVEL_W-1:0] low_level,
  output logic [LEVEL_W-1:0] high_level
);
  logic [COUNT_W-1:0] hist [LEVELS];
  logic [LEVEL_W-1:0] tab [LEVELS];
  logic [COUNT_W-1:0] hist_q;
  logic [LEVEL_W-1:0] tab_q;
  logic [LEVEL_W-1:0] px_q;
  logic [FRAC_W-1:0] bottom_fraction;
  logic [FRAC_W-1:0] upper_fraction;
  logic [COUNT_W-1:0] pixel_total;
  logic [LIMIT_W-1:0] bot_lim;
  logic [LIMIT_W-1:0] top_lim;
  logic [COUNT_W-1:0] cum;
  logic [LEVEL_W-1:0] lo;
  logic [LEVEL_W-1:0] hi;
  logic built;
  logic [LEVEL_W-1:0] den;
  logic [LEVEL_W-1:0] dividend;
  logic [LEVEL_W:0] rem;
  logic [LEVEL_W-1:0] q0;
  logic [LEVEL_W-1:0] acc_q;
  logic [LEVEL_W:0] acc_r;
  logic [LEVEL_W-1:0] hist_addr;
  logic [COUNT_W-1:0] cum_next;
  logic [LIMIT_W-1:0] cum_scaled;
  logic [IDX_W-1:0] idx_m1;
  logic up;
  logic eq;
  logic [LEVEL_W:0] rem_shift;
  logic [LEVEL_W-1:0] pos;
  logic pos_m;
  logic [LEVEL_W:0] r_sum;
  logic carry;
  logic [LEVEL_W:0] acc_r_next;
  logic [LEVEL_W+1:0] q_sum;
  logic [LEVEL_W-1:0] acc_q_next;
  logic [LEVEL_W-1:0] fill_val;
  logic count_en;

  assign hist_addr = cmd.clr ? cmd.idx[LEVEL_W-1:0] : pixel;
  assign cum_next = cum + hist_q;
  assign cum_scaled = LIMIT_W'({cum_next, 16'b0});
  assign idx_m1 = cmd.idx - IDX_W'(1);
  assign up = hi >= lo;
  assign eq = hi == lo;
  assign count_en = pixel_total < MAX_FRAME_PIXELS;
  assign rem_shift = {rem[LEVEL_W-1:0], dividend[LEVEL_W-1]};
  assign pos = up ? cmd.idx[LEVEL_W-1:0] : ~cmd.idx[LEVEL_W-1:0];
  assign pos_m = up ? (pos > lo) : (pos < lo);
  assign r_sum = acc_r + {1'b0, rem[LEVEL_W-1:0]};
  assign carry = r_sum >= {1'b0, den};
  assign acc_r_next = carry ? r_sum - {1'b0, den} : r_sum;
  assign q_sum = {2'b0, acc_q} + {2'b0, q0} + {{(LEVEL_W+1){1'b0}}, carry};
  assign acc_q_next = (q_sum > {2'b0, OUT_MAX}) ? OUT_MAX : q_sum[LEVEL_W-1:0];

  always_comb begin
    if (eq) begin
      fill_val = (pos > lo) ? OUT_MAX : '0;
    end else if (!pos_m) begin
      fill_val = '0;
    end else begin
      fill_val = acc_q_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hist_rd || cmd.clr) begin
      hist_q <= hist[hist_addr];
    end
    if (cmd.clr) begin
      hist[cmd.idx[LEVEL_W-1:0]] <= '0;
    end else if (cmd.hist_inc && count_en) begin
      hist[px_q] <= hist_q + COUNT_W'(1);
    end
    if (cmd.hist_rd || cmd.tab_rd) begin
      px_q <= pixel;
    end
    if (cmd.tab_rd) begin
      tab_q <= tab[pixel];
    end
    if (cmd.fill) begin
      tab[pos] <= fill_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bottom_fraction <= BOTTOM_RESET;
      upper_fraction <= UPPER_RESET;
      pixel_total <= '0;
      built <= 1'b0;
      lo <= '0;
      hi <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_BOTTOM) begin
          bottom_fraction <= cfg_data;
        end else begin
          upper_fraction <= cfg_data;
        end
      end
      if (cmd.walk_start) begin
        pixel_total <= '0;
        lo <= '0;
        hi <= '0;
      end else if (cmd.hist_inc && count_en) begin
        pixel_total <= pixel_total + COUNT_W'(1);
      end
      if (cmd.acc) begin
        if (cum_scaled < bot_lim) begin
          lo <= idx_m1[LEVEL_W-1:0];
        end
        if (cum_scaled < top_lim) begin
          hi <= idx_m1[LEVEL_W-1:0];
        end
      end
      if (cmd.fill) begin
        built <= 1'b1;
      end
      if (cmd.out_map || cmd.out_rep) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_start) begin
      bot_lim <= LIMIT_W'(bottom_fraction) * LIMIT_W'(pixel_total);
      top_lim <= LIMIT_W'(upper_fraction) * LIMIT_W'(pixel_total);
      cum <= '0;
    end else if (cmd.acc) begin
      cum <= cum_next;
    end
    if (cmd.div_start) begin
      den <= up ? hi - lo : lo - hi;
      dividend <= OUT_MAX;
      rem <= '0;
      acc_q <= '0;
      acc_r <= '0;
    end else if (cmd.div_step) begin
      dividend <= {dividend[LEVEL_W-2:0], 1'b0};
      if (rem_shift >= {1'b0, den}) begin
        rem <= rem_shift - {1'b0, den};
        q0 <= {q0[LEVEL_W-2:0], 1'b1};
      end else begin
        rem <= rem_shift;
        q0 <= {q0[LEVEL_W-2:0], 1'b0};
      end
    end else if (cmd.fill) begin
      if (pos_m && !eq) begin
        acc_q <= acc_q_next;
        acc_r <= acc_r_next;
      end else begin
        acc_q <= '0;
        acc_r <= '0;
      end
    end
    if (cmd.out_map) begin
      kind <= KIND_MAP;
      mapped_pixel <= built ? tab_q : px_q;
      low_level <= '0;
      high_level <= '0;
    end else if (cmd.out_rep) begin
      kind <= KIND_REPORT;
      mapped_pixel <= '0;
      low_level <= lo;
      high_level <= hi;
    end
  end

  assign status.out_free = !out_valid || !out_stall;
endmodule
`default_nettype wire

>>> hw/rtl/pcs_ctrl.sv
// Controller: sequences counting, mapping, histogram walk, divide and table fill.
`default_nettype none
`include "percentile_contrast_stretch_top_macros.svh"
module pcs_ctrl
  import pcs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic command,
  input  wire logic last,
  input  wire pcs_status_t status,
  output pcs_cmd_t cmd
);
  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_CNT = 4'd2;
  localparam logic [3:0] S_MAP = 4'd3;
  localparam logic [3:0] S_MUL = 4'd4;
  localparam logic [3:0] S_WALK = 4'd5;
  localparam logic [3:0] S_DIV = 4'd6;
  localparam logic [3:0] S_FILL = 4'd7;
  localparam logic [3:0] S_REP = 4'd8;
  localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(LEVELS - 1);

  logic [3:0] state;
  logic [3:0] state_next;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] idx_next;
  logic last_q;
  logic accept;

  assign in_stall = state != S_IDLE;
  assign accept = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    idx_next = idx;
    cmd = '0;
    cmd.idx = idx;
    unique case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        idx_next = idx + IDX_W'(1);
        if (idx == IDX_TOP) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (command == CMD_MAP) begin
            cmd.tab_rd = 1'b1;
            state_next = S_MAP;
          end else begin
            cmd.hist_rd = 1'b1;
            state_next = S_CNT;
          end
        end
      end
      S_CNT: begin
        cmd.hist_inc = 1'b1;
        state_next = last_q ? S_MUL : S_IDLE;
      end
      S_MAP: begin
        if (status.out_free) begin
          cmd.out_map = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_MUL: begin
        cmd.walk_start = 1'b1;
        idx_next = '0;
        state_next = S_WALK;
      end
      S_WALK: begin
        cmd.clr = !idx[IDX_W-1];
        cmd.acc = idx != '0;
        idx_next = idx + IDX_W'(1);
        if (idx[IDX_W-1]) begin
          idx_next = '0;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_start = idx == '0;
        cmd.div_step = idx != '0;
        idx_next = idx + IDX_W'(1);
        if (idx == IDX_W'(DIV_STEPS)) begin
          idx_next = '0;
          state_next = S_FILL;
        end
      end
      S_FILL: begin
        cmd.fill = 1'b1;
        idx_next = idx + IDX_W'(1);
        if (idx == IDX_TOP) begin
          state_next = S_REP;
        end
      end
      S_REP: begin
        if (status.out_free) begin
          cmd.out_rep = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      idx <= '0;
      last_q <= 1'b0;
    end else begin
      state <= state_next;
      idx <= idx_next;
      if (accept) begin
        last_q <= last;
      end
    end
  end

  `PCS_ASSERT(a_count_next, (accept && command == CMD_COUNT) |=> state == S_CNT, "count not started")
  `PCS_ASSERT(a_map_next, (accept && command == CMD_MAP) |=> state == S_MAP, "map not started")
  `PCS_ASSERT(a_walk_end, (state == S_WALK && idx[IDX_W-1]) |=> state == S_DIV, "walk overrun")
  `PCS_ASSERT_ALWAYS(a_reset_clear, rst |=> (state == S_CLEAR && in_stall), "no clear after reset")
endmodule
`default_nettype wire

>>> hw/rtl/percentile_contrast_stretch_top.sv
// Top level of the percentile contrast stretch: controller plus datapath.
//
// channel   direction  handshake            payload
// input     in         in_valid/in_stall    command, pixel, last
// output    out        out_valid/out_stall  kind, mapped_pixel, low_level, high_level
// config    in         cfg_we               cfg_index, cfg_data
//
// Counting and mapping transactions each do a histogram or table read, then an update.
// The last counted pixel starts a build: the multiply step, the histogram walk, the divide,
// the table fill, then the levels report.
// After reset a clearing pass runs over the histogram; input is stalled meanwhile.
// A result waiting on out_stall holds the controller until the output register frees.
`default_nettype none
module percentile_contrast_stretch_top
  import pcs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic command,
  input  wire logic [LEVEL_W-1:0] pixel,
  input  wire logic last,
  output logic out_valid,
  input  wire logic out_stall,
  output logic kind,
  output logic [LEVEL_W-1:0] mapped_pixel,
  output logic [LEVEL_W-1:0] low_level,
  output logic [LEVEL_W-1:0] high_level,
  input  wire logic cfg_we,
  input  wire logic cfg_index,
  input  wire logic [FRAC_W-1:0] cfg_data
);
  pcs_cmd_t cmd;
  pcs_status_t status;

  pcs_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .command(command),
    .last(last),
    .status(status),
    .cmd(cmd)
  );

  pcs_dp u_dp (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .status(status),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .pixel(pixel),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .kind(kind),
    .mapped_pixel(mapped_pixel),
    .low_level(low_level),
    .high_level(high_level)
  );
endmodule
`default_nettype wire
